// File: hdl/mer_pkg.sv
// Shared types and constants for the MIDI event mapping router.
`timescale 1ns / 1ps
package mer_pkg;

    // Input item modes
    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_EVENT  = 2'd2;
    localparam logic [1:0] MODE_SPARE  = 2'd3;

    // Entry actions
    localparam logic [2:0] ACT_TRIGGER = 3'd0;
    localparam logic [2:0] ACT_BOOL    = 3'd1;
    localparam logic [2:0] ACT_CONT    = 3'd2;
    localparam logic [2:0] ACT_TWOS    = 3'd3;
    localparam logic [2:0] ACT_SHIFT   = 3'd4;

    // Entry message kinds
    localparam logic [1:0] KIND_NOTE_ANY = 2'd0;
    localparam logic [1:0] KIND_NOTE_ON  = 2'd1;
    localparam logic [1:0] KIND_NOTE_OFF = 2'd2;
    localparam logic [1:0] KIND_CC       = 2'd3;

    // Entry output forms
    localparam logic [1:0] FORM_SCALED = 2'd0;
    localparam logic [1:0] FORM_REAL   = 2'd1;
    localparam logic [1:0] FORM_RAW    = 2'd2;

    // Result kinds
    localparam logic [1:0] OUT_TRIGGER = 2'd0;
    localparam logic [1:0] OUT_INT     = 2'd1;
    localparam logic [1:0] OUT_REAL    = 2'd2;
    localparam logic [1:0] OUT_BOOL    = 2'd3;

    // MIDI status codes
    localparam logic [7:0] STATUS_TYPE_MASK = 8'hF0;
    localparam logic [7:0] STATUS_CHAN_MASK = 8'h0F;
    localparam logic [7:0] STATUS_NOTE_OFF  = 8'h80;
    localparam logic [7:0] STATUS_NOTE_ON   = 8'h90;
    localparam logic [7:0] STATUS_CC        = 8'hB0;

    localparam int          MAX_RESULTS = 16;
    localparam int          RES_W       = 5;
    localparam int          VAL_W       = 41;
    localparam int          SUM_W       = 40;
    localparam int          DIV_W       = 44;
    localparam int          DIV_RADIX_B = 4;
    localparam int          DIV_STEPS   = DIV_W / DIV_RADIX_B;
    localparam logic [7:0]  MIDI_DIV    = 8'd127;
    localparam int          FRAC_B      = 16;

    typedef enum logic [1:0] {
        CMD_CLEAR,
        CMD_APPEND,
        CMD_EVENT
    } cmd_op_t;

    typedef struct packed {
        logic [3:0]         channel;
        logic [6:0]         number;
        logic [1:0]         kind;
        logic [2:0]         action;
        logic signed [3:0]  player;
        logic [7:0]         signal;
        logic [1:0]         form;
        logic signed [31:0] gain;
        logic signed [31:0] bias;
    } entry_t;

    typedef struct packed {
        logic [3:0] channel;
        logic [6:0] number;
        logic [6:0] value;
        logic       is_on;
        logic       is_off;
        logic       is_cc;
    } event_t;

    typedef struct packed {
        cmd_op_t op;
        entry_t  entry;
        event_t  evt;
    } cmd_t;

    typedef struct packed {
        logic [1:0]              kind;
        logic signed [3:0]       player;
        logic [7:0]              signal;
        logic signed [VAL_W-1:0] value;
        logic                    flag;
        logic                    last;
    } result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_EVAL,
        S_MUL,
        S_SUM,
        S_POST,
        S_SCALE,
        S_DIV,
        S_EMIT,
        S_FLUSH
    } back_state_t;

endpackage

// File: hdl/mer_fifo.sv
// Small synchronous queue carrying a packed struct.
`timescale 1ns / 1ps
module mer_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  T     wdata,
    output logic full,
    input  logic pop,
    output logic empty,
    output T     rdata
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T              mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end
endmodule

// File: hdl/mer_front.sv
// Request front end: decodes the mode and MIDI status into a command.
`timescale 1ns / 1ps
module mer_front (
    input  logic               push,
    input  logic               cmd_full,
    input  logic [1:0]         mode,
    input  logic [7:0]         event_status,
    input  logic [6:0]         event_number,
    input  logic [6:0]         event_value,
    input  logic [3:0]         entry_channel,
    input  logic [1:0]         entry_kind,
    input  logic [2:0]         entry_action,
    input  logic signed [3:0]  entry_player,
    input  logic [7:0]         entry_signal,
    input  logic [1:0]         entry_form,
    input  logic signed [31:0] entry_gain,
    input  logic signed [31:0] entry_bias,
    output logic               cmd_push,
    output mer_pkg::cmd_t      cmd
);
    import mer_pkg::*;

    logic [7:0] status_type;
    logic [7:0] status_chan;
    logic       known_mode;

    assign status_type = event_status & STATUS_TYPE_MASK;
    assign status_chan = event_status & STATUS_CHAN_MASK;

    always_comb
    begin
        known_mode = 1'b1;
        cmd.op     = CMD_CLEAR;
        unique case (mode)
            MODE_CLEAR:  cmd.op = CMD_CLEAR;
            MODE_APPEND: cmd.op = CMD_APPEND;
            MODE_EVENT:  cmd.op = CMD_EVENT;
            default:     known_mode = 1'b0;
        endcase

        cmd.entry.channel = entry_channel;
        cmd.entry.number  = event_number;
        cmd.entry.kind    = entry_kind;
        cmd.entry.action  = entry_action;
        cmd.entry.player  = entry_player;
        cmd.entry.signal  = entry_signal;
        cmd.entry.form    = entry_form;
        cmd.entry.gain    = entry_gain;
        cmd.entry.bias    = entry_bias;

        cmd.evt.channel = status_chan[3:0];
        cmd.evt.number  = event_number;
        cmd.evt.value   = event_value;
        cmd.evt.is_on   = (status_type == STATUS_NOTE_ON);
        cmd.evt.is_off  = (status_type == STATUS_NOTE_OFF);
        cmd.evt.is_cc   = (status_type == STATUS_CC);
    end

    // unknown modes are accepted and dropped here
    assign cmd_push = push && !cmd_full && known_mode;
endmodule

// File: hdl/mer_back.sv
// Back end: mapping table, table walk, value arithmetic and result ordering.
`timescale 1ns / 1ps
module mer_back #(
    parameter int TABLE_DEPTH = 16,
    parameter int SCALE_UNIT  = 1000
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  mer_pkg::cmd_t    cmd,
    output logic             cmd_pop,
    input  logic             res_full,
    output logic             res_push,
    output mer_pkg::result_t res
);
    import mer_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int OS_W  = $clog2(SCALE_UNIT + 1);
    localparam int SP_W  = SUM_W + OS_W;
    localparam logic [OS_W-1:0] OS_K = OS_W'(SCALE_UNIT);

    entry_t      table_mem [TABLE_DEPTH];
    entry_t      ent_reg;
    logic        mem_we;

    back_state_t             state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic [RES_W-1:0]        nres_reg, nres_next;
    event_t                  evt_reg, evt_next;
    logic signed [SUM_W-1:0] prod_reg, prod_next;
    logic signed [SUM_W-1:0] bterm_reg, bterm_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic                    neg_reg, neg_next;
    logic [DIV_W-1:0]        mag_reg, mag_next;
    logic [6:0]              rem_reg, rem_next;
    logic [3:0]              dcnt_reg, dcnt_next;
    logic [1:0]              okind_reg, okind_next;
    logic                    div_after_reg, div_after_next;
    result_t                 pend_reg, pend_next;
    logic                    pend_valid_reg, pend_valid_next;

    logic                    hit;
    logic                    kind_ok;
    logic signed [7:0]       mul_op;
    logic [SUM_W-1:0]        sum_abs;
    logic [SP_W-1:0]         scale_prod;
    logic [7:0]              trial;
    logic [6:0]              rem_w;
    logic [DIV_W-1:0]        quo_w;
    logic signed [VAL_W:0]   sval;
    logic signed [VAL_W-1:0] val_sat;
    result_t                 new_res;

    // table store, registered read at the walk index
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[count_reg[IDX_W-1:0]] <= cmd.entry;
        end
        ent_reg <= table_mem[idx_reg[IDX_W-1:0]];
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        nres_next       = nres_reg;
        evt_next        = evt_reg;
        prod_next       = prod_reg;
        bterm_next      = bterm_reg;
        sum_next        = sum_reg;
        neg_next        = neg_reg;
        mag_next        = mag_reg;
        rem_next        = rem_reg;
        dcnt_next       = dcnt_reg;
        okind_next      = okind_reg;
        div_after_next  = div_after_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        cmd_pop         = 1'b0;
        mem_we          = 1'b0;
        res_push        = 1'b0;
        res             = pend_reg;
        res.last        = (state_reg == S_FLUSH);

        unique case (ent_reg.kind)
            KIND_NOTE_ANY: kind_ok = evt_reg.is_on || evt_reg.is_off;
            KIND_NOTE_ON:  kind_ok = evt_reg.is_on;
            KIND_NOTE_OFF: kind_ok = evt_reg.is_off;
            default:       kind_ok = evt_reg.is_cc;
        endcase
        hit = (ent_reg.channel == evt_reg.channel) && (ent_reg.number == evt_reg.number)
              && kind_ok && (nres_reg < RES_W'(MAX_RESULTS));

        mul_op = (ent_reg.action == ACT_TWOS) ? $signed({evt_reg.value[6], evt_reg.value})
                                              : $signed({1'b0, evt_reg.value});
        sum_abs    = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        scale_prod = mag_reg[SUM_W-1:0] * OS_K;

        // radix-16 step of division by 127: four narrow restoring steps
        rem_w = rem_reg;
        quo_w = mag_reg;
        for (int k = 0; k < DIV_RADIX_B; k++)
        begin
            trial = {rem_w, quo_w[DIV_W-1]};
            quo_w = {quo_w[DIV_W-2:0], (trial >= MIDI_DIV)};
            rem_w = (trial >= MIDI_DIV) ? 7'(trial - MIDI_DIV) : trial[6:0];
        end

        sval = $signed({1'b0, mag_reg[VAL_W-1:0]});
        if (neg_reg)
        begin
            sval = -sval;
        end
        if (sval > $signed({2'b00, {(VAL_W-1){1'b1}}}))
        begin
            val_sat = {1'b0, {(VAL_W-1){1'b1}}};
        end
        else if (sval < $signed({2'b11, {(VAL_W-1){1'b0}}}))
        begin
            val_sat = {1'b1, {(VAL_W-1){1'b0}}};
        end
        else
        begin
            val_sat = sval[VAL_W-1:0];
        end

        new_res.kind   = okind_reg;
        new_res.player = ent_reg.player[3] ? 4'sb1111 : ent_reg.player;
        new_res.signal = ent_reg.signal;
        new_res.value  = ((okind_reg == OUT_TRIGGER) || (okind_reg == OUT_BOOL)) ? '0 : val_sat;
        new_res.flag   = (okind_reg == OUT_BOOL) && (evt_reg.value != 7'd0) && !evt_reg.is_off;
        new_res.last   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.op)
                        CMD_CLEAR: count_next = '0;
                        CMD_APPEND:
                        begin
                            if (count_reg < CNT_W'(TABLE_DEPTH))
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_EVENT:
                        begin
                            evt_next   = cmd.evt;
                            idx_next   = '0;
                            nres_next  = '0;
                            state_next = S_FETCH;
                        end
                        default: ;
                    endcase
                end
            end
            S_FETCH:
            begin
                state_next = (idx_reg >= count_reg) ? S_FLUSH : S_EVAL;
            end
            S_EVAL:
            begin
                if (hit && (ent_reg.action <= ACT_TWOS)
                    && !((ent_reg.action == ACT_BOOL) && ent_reg.player[3]))
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_FETCH;
                end
            end
            S_MUL:
            begin
                prod_next = SUM_W'(ent_reg.gain * mul_op);
                if (ent_reg.action == ACT_TWOS)
                begin
                    bterm_next = SUM_W'(ent_reg.bias);
                end
                else
                begin
                    bterm_next = (SUM_W'(ent_reg.bias) <<< 7) - SUM_W'(ent_reg.bias);
                end
                state_next = S_SUM;
            end
            S_SUM:
            begin
                sum_next   = prod_reg + bterm_reg;
                state_next = S_POST;
            end
            S_POST:
            begin
                neg_next       = sum_reg[SUM_W-1];
                mag_next       = DIV_W'(sum_abs);
                rem_next       = '0;
                dcnt_next      = '0;
                div_after_next = (ent_reg.action == ACT_CONT);
                unique case (ent_reg.action)
                    ACT_TRIGGER:
                    begin
                        okind_next = OUT_TRIGGER;
                        if ((ent_reg.kind == KIND_CC) && (sum_reg <= 0))
                        begin
                            idx_next   = idx_reg + 1'b1;
                            state_next = S_FETCH;
                        end
                        else
                        begin
                            state_next = S_EMIT;
                        end
                    end
                    ACT_BOOL:
                    begin
                        okind_next = OUT_BOOL;
                        state_next = S_EMIT;
                    end
                    ACT_CONT:
                    begin
                        if (ent_reg.form == FORM_REAL)
                        begin
                            okind_next = OUT_REAL;
                            state_next = S_DIV;
                        end
                        else
                        begin
                            okind_next = OUT_INT;
                            state_next = S_SCALE;
                        end
                    end
                    default:
                    begin
                        if (ent_reg.form == FORM_REAL)
                        begin
                            okind_next = OUT_REAL;
                            state_next = S_EMIT;
                        end
                        else if (ent_reg.form == FORM_RAW)
                        begin
                            okind_next = OUT_INT;
                            mag_next   = DIV_W'(sum_abs >> FRAC_B);
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            okind_next = OUT_INT;
                            state_next = S_SCALE;
                        end
                    end
                endcase
            end
            S_SCALE:
            begin
                mag_next   = DIV_W'(scale_prod >> FRAC_B);
                state_next = div_after_reg ? S_DIV : S_EMIT;
            end
            S_DIV:
            begin
                mag_next  = quo_w;
                rem_next  = rem_w;
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == 4'(DIV_STEPS - 1))
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // hold one result back so the final one can carry last
                if (!pend_valid_reg || !res_full)
                begin
                    res_push        = pend_valid_reg;
                    pend_next       = new_res;
                    pend_valid_next = 1'b1;
                    nres_next       = nres_reg + 1'b1;
                    idx_next        = idx_reg + 1'b1;
                    state_next      = S_FETCH;
                end
            end
            S_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (!res_full)
                begin
                    res_push        = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            nres_reg       <= '0;
            dcnt_reg       <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            nres_reg       <= nres_next;
            dcnt_reg       <= dcnt_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        evt_reg       <= evt_next;
        prod_reg      <= prod_next;
        bterm_reg     <= bterm_next;
        sum_reg       <= sum_next;
        neg_reg       <= neg_next;
        mag_reg       <= mag_next;
        rem_reg       <= rem_next;
        okind_reg     <= okind_next;
        div_after_reg <= div_after_next;
        pend_reg      <= pend_next;
    end
endmodule

// File: hdl/midi_event_mapping_router_top.sv
// MIDI event mapping router, top level: front end, request queue, back end, result queue.
// Requests clear the mapping table, append an entry, or present a MIDI event; an event
// walks the table in order and each matching entry with an action up to ACT_TWOS
// yields a trigger, scaled or raw integer, Q16.16 real or bool result, save CC triggers
// whose sum is not above zero and bool entries with a negative player; the last result
// of an event is marked by out_last. Each entry walked is fetched, then evaluated (one
// table read port, one entry per visit); a result entry passes multiply, sum and post
// steps, then scaling for a scaled value and the division by 127 of continuous values
// (a radix-16 divide unit), then emit, which waits while the result queue is full.
// A two-deep request queue lets new requests be taken while an event is walked, and a
// two-deep result queue decouples the output side.
`timescale 1ns / 1ps
module midi_event_mapping_router_top #(
    parameter int TABLE_DEPTH = 16,
    parameter int SCALE_UNIT  = 1000
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         mode,
    input  logic [7:0]         event_status,
    input  logic [6:0]         event_number,
    input  logic [6:0]         event_value,
    input  logic [3:0]         entry_channel,
    input  logic [1:0]         entry_kind,
    input  logic [2:0]         entry_action,
    input  logic signed [3:0]  entry_player,
    input  logic [7:0]         entry_signal,
    input  logic [1:0]         entry_form,
    input  logic signed [31:0] entry_gain,
    input  logic signed [31:0] entry_bias,
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         out_kind,
    output logic signed [3:0]  out_player,
    output logic [7:0]         out_signal,
    output logic signed [40:0] out_value,
    output logic               out_flag,
    output logic               out_last
);
    import mer_pkg::*;

    cmd_t    fe_cmd, q_cmd;
    logic    fe_push, cmd_full, cmd_empty, cmd_pop;
    result_t be_res, q_res;
    logic    res_push, res_full;

    mer_front u_front (
        .push          (push),
        .cmd_full      (cmd_full),
        .mode          (mode),
        .event_status  (event_status),
        .event_number  (event_number),
        .event_value   (event_value),
        .entry_channel (entry_channel),
        .entry_kind    (entry_kind),
        .entry_action  (entry_action),
        .entry_player  (entry_player),
        .entry_signal  (entry_signal),
        .entry_form    (entry_form),
        .entry_gain    (entry_gain),
        .entry_bias    (entry_bias),
        .cmd_push      (fe_push),
        .cmd           (fe_cmd)
    );

    mer_fifo #(.T(cmd_t), .DEPTH(2)) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fe_push),
        .wdata (fe_cmd),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .empty (cmd_empty),
        .rdata (q_cmd)
    );

    mer_back #(.TABLE_DEPTH(TABLE_DEPTH), .SCALE_UNIT(SCALE_UNIT)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!cmd_empty),
        .cmd       (q_cmd),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (be_res)
    );

    mer_fifo #(.T(result_t), .DEPTH(2)) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (be_res),
        .full  (res_full),
        .pop   (pop),
        .empty (empty),
        .rdata (q_res)
    );

    assign full       = cmd_full;
    assign out_kind   = q_res.kind;
    assign out_player = q_res.player;
    assign out_signal = q_res.signal;
    assign out_value  = q_res.value;
    assign out_flag   = q_res.flag;
    assign out_last   = q_res.last;
endmodule
